/* hdl/rcpa_pkg.sv */
package rcpa_pkg;

  // Fixed field widths of the command and result channels.
  localparam int PAGE_W   = 16;
  localparam int CMD_W    = 3;
  localparam int CNT_W    = 8;
  localparam int STATUS_W = 3;
  localparam int FREE_W   = 17;
  localparam int LIMIT_W  = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INC   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEC   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PAGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CORRUPT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'd1;

  localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET = 17'd65536;
  localparam logic [FREE_W-1:0]  COUNTER_MAX      = 17'h1FFFF;
  localparam logic [CNT_W-1:0]   CNT_OUT_MAX      = 8'hFF;

  // Conditions on a reference count, seen by the command sequencer.
  typedef struct packed {
    logic is_zero;
    logic is_max;
    logic above_one;
  } rcpa_cnt_flags_t;

endpackage

/* hdl/rcpa_count_alu.sv */
module rcpa_count_alu import rcpa_pkg::*; #(
  parameter int REF_BITS = 8
) (
  input  logic [REF_BITS-1:0] count_in,
  input  logic                dec,
  output logic [REF_BITS-1:0] count_out,
  output rcpa_cnt_flags_t     flags
);

  // One incrementer serves both directions: adding all ones subtracts one.
  assign count_out = count_in + (dec ? {REF_BITS{1'b1}} : REF_BITS'(1));

  // Limits that decide saturation, underflow and the push on free.
  assign flags.is_zero   = (count_in == '0);
  assign flags.is_max    = &count_in;
  assign flags.above_one = (count_in[REF_BITS-1:1] != '0);

endmodule

/* hdl/refcounted_page_allocator.sv */
// Reference-counted page allocator: each command (alloc, free, increase,
// decrease, read count) gives exactly one result. The idle state takes a
// command and reads the count and link memories; the execute state updates
// them. No new command is taken before the last has left the execute state,
// and a stalled result holds the block in its execute state. After reset the
// block clears the reference count memory, one entry per cycle, before it
// takes its first command; configuration writes are taken at any time. The
// free list is LIFO: free pushes a page whose count is or becomes zero,
// alloc pops the head and sets its count to one.
module refcounted_page_allocator import rcpa_pkg::*; #(
  parameter int NUM_PAGES = 65536,
  parameter int REF_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // Command channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [PAGE_W-1:0]     page,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PAGE_W-1:0]     page_out,
  output logic [CNT_W-1:0]      ref_count,
  output logic [STATUS_W-1:0]   status,
  output logic [FREE_W-1:0]     free_pages,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam logic [IDX_W-1:0] CLEAR_LAST = IDX_W'(NUM_PAGES - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]          state;
  logic [IDX_W-1:0]    clear_addr;
  logic [PAGE_W-1:0]   first_page;
  logic [LIMIT_W-1:0]  page_limit;
  logic [IDX_W-1:0]    list_head;
  logic                list_nonempty;
  logic [FREE_W-1:0]   free_counter;

  logic [CMD_W-1:0]    op_cmd;
  logic [PAGE_W-1:0]   op_page;
  logic [IDX_W-1:0]    op_addr;
  logic                op_bad;

  logic [REF_BITS-1:0] ref_mem [NUM_PAGES];
  logic [IDX_W-1:0]    link_mem [NUM_PAGES];
  logic [REF_BITS-1:0] cnt_rd;
  logic [IDX_W-1:0]    link_rd;

  logic                in_xfer;
  logic                exec_go;
  logic [31:0]         page_ext;
  logic [IDX_W-1:0]    page_idx;
  logic                page_ok;
  logic [IDX_W-1:0]    rd_addr;

  logic [REF_BITS-1:0] alu_out;
  rcpa_cnt_flags_t     alu_flags;

  logic                rc_we;
  logic [IDX_W-1:0]    rc_waddr;
  logic [REF_BITS-1:0] rc_wdata;
  logic                link_we;
  logic [IDX_W-1:0]    list_head_next;
  logic                list_nonempty_next;
  logic [FREE_W-1:0]   free_counter_next;
  logic [FREE_W-1:0]   free_dec;
  logic [31:0]         head_ext;
  logic [PAGE_W-1:0]   res_page;
  logic [REF_BITS-1:0] res_cnt;
  logic [31:0]         res_cnt_ext;
  logic [STATUS_W-1:0] res_status;

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign exec_go   = (state == S_EXEC) && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;

  // Page checks are done as the command is taken.
  assign page_ext = 32'(page);
  assign page_idx = page_ext[IDX_W-1:0];
  assign page_ok  = ({1'b0, page} < page_limit) && (page_ext < 32'(NUM_PAGES)) &&
                    !((cmd == CMD_FREE) && (page < first_page));
  assign rd_addr  = (cmd == CMD_ALLOC) ? list_head : page_idx;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= '0;
      page_limit <= PAGE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIRST_PAGE: first_page <= cfg_data[PAGE_W-1:0];
        CFG_PAGE_LIMIT: page_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: clearing pass after reset, then take and execute commands.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + IDX_W'(1);
          if (clear_addr == CLEAR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Latch the command as it is taken.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_cmd  <= cmd;
      op_page <= page;
      op_addr <= rd_addr;
      op_bad  <= !page_ok && (cmd != CMD_ALLOC);
    end
  end

  // Count and link memories, read as the command is taken.
  always_ff @(posedge clk) begin
    if (rc_we) begin
      ref_mem[rc_waddr] <= rc_wdata;
    end
    if (in_xfer) begin
      cnt_rd <= ref_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[op_addr] <= list_head;
    end
    if (in_xfer) begin
      link_rd <= link_mem[rd_addr];
    end
  end

  // Shared count unit.
  rcpa_count_alu #(
    .REF_BITS(REF_BITS)
  ) u_alu (
    .count_in (cnt_rd),
    .dec      (op_cmd != CMD_INC),
    .count_out(alu_out),
    .flags    (alu_flags)
  );

  assign head_ext = 32'(list_head);
  assign free_dec = (free_counter != '0) ? free_counter - FREE_W'(1) : free_counter;

  // Command execution: memory updates, list updates and the result.
  always_comb begin
    rc_we              = 1'b0;
    rc_waddr           = op_addr;
    rc_wdata           = alu_out;
    link_we            = 1'b0;
    list_head_next     = list_head;
    list_nonempty_next = list_nonempty;
    free_counter_next  = free_counter;
    res_page           = op_page;
    res_cnt            = cnt_rd;
    res_status         = ST_OK;
    if (state == S_CLEAR) begin
      rc_we    = 1'b1;
      rc_waddr = clear_addr;
      rc_wdata = '0;
    end else if (op_cmd == CMD_ALLOC) begin
      if (!list_nonempty || (head_ext >= 32'(NUM_PAGES))) begin
        res_page   = '0;
        res_cnt    = '0;
        res_status = ST_NO_MEM;
      end else if (!alu_flags.is_zero) begin
        // The head page is still referenced, so the list is corrupt.
        res_page   = head_ext[PAGE_W-1:0];
        res_status = ST_CORRUPT;
      end else begin
        rc_we              = exec_go;
        rc_wdata           = REF_BITS'(1);
        list_head_next     = link_rd;
        free_counter_next  = free_dec;
        list_nonempty_next = (free_dec != '0);
        res_page           = head_ext[PAGE_W-1:0];
        res_cnt            = REF_BITS'(1);
      end
    end else if (op_bad) begin
      res_cnt    = '0;
      res_status = ST_BAD_PAGE;
    end else begin
      case (op_cmd)
        CMD_FREE: begin
          if (alu_flags.above_one) begin
            rc_we   = exec_go;
            res_cnt = alu_out;
          end else if (free_counter == COUNTER_MAX) begin
            res_status = ST_SATURATED;
          end else begin
            // The count is or becomes zero: push the page.
            rc_we              = exec_go;
            rc_wdata           = '0;
            link_we            = exec_go;
            list_head_next     = op_addr;
            list_nonempty_next = 1'b1;
            free_counter_next  = free_counter + FREE_W'(1);
            res_cnt            = '0;
          end
        end
        CMD_INC: begin
          if (alu_flags.is_max) begin
            res_status = ST_SATURATED;
          end else begin
            rc_we   = exec_go;
            res_cnt = alu_out;
          end
        end
        CMD_DEC: begin
          if (alu_flags.is_zero) begin
            res_status = ST_UNDERFLOW;
          end else begin
            rc_we   = exec_go;
            res_cnt = alu_out;
          end
        end
        default: ;
      endcase
    end
  end

  // Free list registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      list_head     <= '0;
      list_nonempty <= 1'b0;
      free_counter  <= '0;
    end else if (exec_go) begin
      list_head     <= list_head_next;
      list_nonempty <= list_nonempty_next;
      free_counter  <= free_counter_next;
    end
  end

  assign res_cnt_ext = 32'(res_cnt);

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      page_out   <= res_page;
      ref_count  <= (res_cnt_ext > 32'(CNT_OUT_MAX)) ? CNT_OUT_MAX : res_cnt_ext[CNT_W-1:0];
      status     <= res_status;
      free_pages <= free_counter_next;
    end
  end

  // The list is marked nonempty exactly when the free counter is nonzero.
  a_nonempty_matches_counter: assert property (
    @(posedge clk) disable iff (rst)
    list_nonempty == (free_counter != '0)
  ) else $error("list_nonempty disagrees with free_counter");

  // A new result only appears after an execute cycle.
  a_result_from_exec: assert property (
    @(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EXEC
  ) else $error("result appeared without an execute cycle");

  // List state changes only when a command completes.
  a_list_stable: assert property (
    @(posedge clk) disable iff (rst)
    (state != S_EXEC) |=> $stable(free_counter) && $stable(list_head)
  ) else $error("free list changed outside command execution");

  // The clearing pass ends only after the last entry.
  a_clear_complete: assert property (
    @(posedge clk) disable iff (rst)
    ($past(state) == S_CLEAR && state == S_IDLE) |-> $past(clear_addr) == CLEAR_LAST
  ) else $error("clearing pass ended early");

endmodule
